// ----- src/prt_pkg.sv -----
package prt_pkg;

  localparam int DEPTH  = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int KEY_W  = 16;
  localparam int VAL_W  = 16;
  localparam int ACT_W  = 2;
  localparam int POS_W  = 6;
  localparam int STAT_W = 2;
  // Width in which positions and the record count are compared without overflow.
  localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_POS   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic             en;
    logic             ins;
    logic             del;
    logic             cmp;
    logic             rd;
    logic [IDX_W-1:0] slot;
    logic [CNT_W-1:0] count;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } cmd_t;

endpackage

// ----- src/prt_cell.sv -----
module prt_cell (
  input  logic                      clk,
  input  prt_pkg::cmd_t             cmd,
  input  logic [prt_pkg::IDX_W-1:0] idx,
  input  logic [prt_pkg::KEY_W-1:0] prev_key,
  input  logic [prt_pkg::VAL_W-1:0] prev_value,
  input  logic [prt_pkg::KEY_W-1:0] next_key,
  input  logic [prt_pkg::VAL_W-1:0] next_value,
  output logic [prt_pkg::KEY_W-1:0] key,
  output logic [prt_pkg::VAL_W-1:0] value,
  output logic                      hit
);

  logic [prt_pkg::KEY_W-1:0] key_r;
  logic [prt_pkg::VAL_W-1:0] value_r;
  logic                      hit_r;
  logic                      occupied;

  assign occupied = prt_pkg::CNT_W'(idx) < cmd.count;

  always_ff @(posedge clk) begin
    if (cmd.en) begin
      if (cmd.ins && idx == cmd.slot) begin
        key_r   <= cmd.key;
        value_r <= cmd.value;
      end else if (cmd.ins && idx > cmd.slot) begin
        key_r   <= prev_key;
        value_r <= prev_value;
      end else if (cmd.del && idx >= cmd.slot) begin
        key_r   <= next_key;
        value_r <= next_value;
      end
      // The hit flag marks the matching record for a search, or the addressed one for a read.
      hit_r <= (cmd.cmp && occupied && key_r == cmd.key) || (cmd.rd && idx == cmd.slot);
    end
  end

  assign key   = key_r;
  assign value = value_r;
  assign hit   = hit_r;

endmodule

// ----- src/positional_record_table_unit.sv -----
// Ordered table of up to 32 key/value records held in a chain of cells. A request is taken
// when start is high and busy is low; busy is then high for one cycle and the result appears
// on the out_ ports, marked by out_strobe, in the cycle after that, and a new request may be issued
// while the previous result is on the outputs. Insert and delete move every later record at once
// by each cell loading its neighbour; search compares all cells at once and the lowest matching
// position wins. The result is shown for exactly one cycle and cannot be held off, so the receiver
// must take it then.
module positional_record_table_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [prt_pkg::ACT_W-1:0]  in_action,
  input  logic [prt_pkg::POS_W-1:0]  in_position,
  input  logic [prt_pkg::KEY_W-1:0]  in_key,
  input  logic [prt_pkg::VAL_W-1:0]  in_value,
  output logic                       out_strobe,
  output logic [prt_pkg::STAT_W-1:0] out_status,
  output logic [prt_pkg::POS_W-1:0]  out_found_position,
  output logic [prt_pkg::KEY_W-1:0]  out_key_out,
  output logic [prt_pkg::VAL_W-1:0]  out_value_out,
  output logic [prt_pkg::POS_W-1:0]  out_record_count
);

  logic                       accept;
  logic                       pending_r;
  logic [prt_pkg::CNT_W-1:0]  count_r;
  logic [prt_pkg::CNT_W-1:0]  count_nxt;
  prt_pkg::action_t           op;
  prt_pkg::action_t           op_r;
  prt_pkg::status_t           status_nxt;
  prt_pkg::status_t           status_r;
  logic [prt_pkg::CMP_W-1:0]  pos_c;
  logic [prt_pkg::CMP_W-1:0]  cnt_c;
  logic [prt_pkg::CMP_W-1:0]  slot_c;
  logic                       ins_pos_ok;
  logic                       rd_pos_ok;
  logic                       is_full;
  prt_pkg::cmd_t              cmd;

  logic [prt_pkg::KEY_W-1:0]  cell_key   [prt_pkg::DEPTH];
  logic [prt_pkg::VAL_W-1:0]  cell_value [prt_pkg::DEPTH];
  logic [prt_pkg::DEPTH-1:0]  hit;
  logic [prt_pkg::IDX_W-1:0]  first_idx;
  logic                       any_hit;

  prt_pkg::status_t           res_status;
  logic [prt_pkg::POS_W-1:0]  res_pos;
  logic [prt_pkg::KEY_W-1:0]  res_key;
  logic [prt_pkg::VAL_W-1:0]  res_value;

  logic                       out_strobe_r;
  prt_pkg::status_t           out_status_r;
  logic [prt_pkg::POS_W-1:0]  out_pos_r;
  logic [prt_pkg::KEY_W-1:0]  out_key_r;
  logic [prt_pkg::VAL_W-1:0]  out_value_r;

  assign accept = start && !pending_r;
  assign busy   = pending_r;
  assign op     = prt_pkg::action_t'(in_action);

  assign pos_c      = prt_pkg::CMP_W'(in_position);
  assign cnt_c      = prt_pkg::CMP_W'(count_r);
  assign slot_c     = pos_c - prt_pkg::CMP_W'(1);
  assign ins_pos_ok = (pos_c != '0) && (pos_c <= cnt_c + prt_pkg::CMP_W'(1));
  assign rd_pos_ok  = (pos_c != '0) && (pos_c <= cnt_c);
  assign is_full    = (cnt_c == prt_pkg::CMP_W'(prt_pkg::DEPTH));

  always_comb begin
    status_nxt = prt_pkg::ST_OK;
    count_nxt  = count_r;
    case (op)
      prt_pkg::ACT_INSERT: begin
        if (!ins_pos_ok) begin
          status_nxt = prt_pkg::ST_BAD_POS;
        end else if (is_full) begin
          status_nxt = prt_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + prt_pkg::CNT_W'(1);
        end
      end
      prt_pkg::ACT_DELETE: begin
        if (!rd_pos_ok) begin
          status_nxt = prt_pkg::ST_BAD_POS;
        end else begin
          count_nxt = count_r - prt_pkg::CNT_W'(1);
        end
      end
      prt_pkg::ACT_SEARCH: begin
        status_nxt = prt_pkg::ST_NOT_FOUND;
      end
      prt_pkg::ACT_READ: begin
        if (!rd_pos_ok) begin
          status_nxt = prt_pkg::ST_BAD_POS;
        end
      end
      default: begin
        status_nxt = prt_pkg::ST_BAD_POS;
      end
    endcase
  end

  always_comb begin
    cmd.en    = accept;
    cmd.ins   = accept && op == prt_pkg::ACT_INSERT && status_nxt == prt_pkg::ST_OK;
    cmd.del   = accept && op == prt_pkg::ACT_DELETE && status_nxt == prt_pkg::ST_OK;
    cmd.cmp   = accept && op == prt_pkg::ACT_SEARCH;
    cmd.rd    = accept && op == prt_pkg::ACT_READ && status_nxt == prt_pkg::ST_OK;
    cmd.slot  = slot_c[prt_pkg::IDX_W-1:0];
    cmd.count = count_r;
    cmd.key   = in_key;
    cmd.value = in_value;
  end

  for (genvar g = 0; g < prt_pkg::DEPTH; g++) begin : g_cell
    logic [prt_pkg::KEY_W-1:0] prev_key;
    logic [prt_pkg::VAL_W-1:0] prev_value;
    logic [prt_pkg::KEY_W-1:0] next_key;
    logic [prt_pkg::VAL_W-1:0] next_value;

    if (g == 0) begin : g_head
      assign prev_key   = '0;
      assign prev_value = '0;
    end else begin : g_link_prev
      assign prev_key   = cell_key[g-1];
      assign prev_value = cell_value[g-1];
    end

    if (g == prt_pkg::DEPTH - 1) begin : g_tail
      assign next_key   = '0;
      assign next_value = '0;
    end else begin : g_link_next
      assign next_key   = cell_key[g+1];
      assign next_value = cell_value[g+1];
    end

    prt_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .idx        (prt_pkg::IDX_W'(g)),
      .prev_key   (prev_key),
      .prev_value (prev_value),
      .next_key   (next_key),
      .next_value (next_value),
      .key        (cell_key[g]),
      .value      (cell_value[g]),
      .hit        (hit[g])
    );
  end

  // Lowest set hit flag; for a read at most one flag is set.
  always_comb begin
    first_idx = '0;
    any_hit   = 1'b0;
    for (int i = prt_pkg::DEPTH - 1; i >= 0; i--) begin
      if (hit[i]) begin
        first_idx = prt_pkg::IDX_W'(i);
        any_hit   = 1'b1;
      end
    end
  end

  always_comb begin
    res_status = status_r;
    res_pos    = '0;
    res_key    = '0;
    res_value  = '0;
    if ((op_r == prt_pkg::ACT_SEARCH || op_r == prt_pkg::ACT_READ) && any_hit) begin
      res_status = prt_pkg::ST_OK;
      res_pos    = prt_pkg::POS_W'(first_idx) + prt_pkg::POS_W'(1);
      res_key    = cell_key[first_idx];
      res_value  = cell_value[first_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r    <= 1'b0;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      pending_r    <= accept;
      count_r      <= accept ? count_nxt : count_r;
      out_strobe_r <= pending_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= op;
      status_r <= status_nxt;
    end
    if (pending_r) begin
      out_status_r <= res_status;
      out_pos_r    <= res_pos;
      out_key_r    <= res_key;
      out_value_r  <= res_value;
    end
  end

  assign out_strobe         = out_strobe_r;
  assign out_status         = out_status_r;
  assign out_found_position = out_pos_r;
  assign out_key_out        = out_key_r;
  assign out_value_out      = out_value_r;
  assign out_record_count   = prt_pkg::POS_W'(count_r);

`ifndef SYNTH
  a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("request taken but block not busy");

  a_busy_strobe : assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_strobe)
    else $error("no result after busy cycle");

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_c <= prt_pkg::CMP_W'(prt_pkg::DEPTH))
    else $error("record count above depth");

  a_read_onehot : assert property (@(posedge clk) disable iff (!rst_n)
    (busy && op_r == prt_pkg::ACT_READ) |-> $onehot0(hit))
    else $error("more than one cell selected for a read");

  a_error_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status != prt_pkg::ST_OK) |->
      (out_found_position == '0 && out_key_out == '0 && out_value_out == '0))
    else $error("rejected request returned record data");
`endif

endmodule
